@@ rtl/rirb_pkg.sv @@
// Package for the ranked insert/remove buffer.
// Holds field widths, mode and status codes, and the command struct that
// the controller broadcasts to the row of storage cells. No dependencies.
`default_nettype none

package rirb_pkg;

  localparam int MODE_W   = 2;
  localparam int RANK_W   = 4;
  localparam int DATA_W   = 8;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  localparam int DEPTH_DEF = 16;

  localparam logic [MODE_W-1:0] MODE_READ    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REPLACE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic              ins;
    logic              rem;
    logic              wr;
    logic              rd;
    logic [RANK_W-1:0] rank;
    logic [DATA_W-1:0] value;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/rirb_in_if.sv @@
// Input channel of the ranked insert/remove buffer.
// Carries valid, ready and one operation beat; widths from rirb_pkg.
`default_nettype none

interface rirb_in_if;
  logic                          valid;
  logic                          ready;
  logic [rirb_pkg::MODE_W-1:0]   mode;
  logic [rirb_pkg::RANK_W-1:0]   rank;
  logic [rirb_pkg::DATA_W-1:0]   value;

  modport source (output valid, output mode, output rank, output value, input ready);
  modport sink (input valid, input mode, input rank, input value, output ready);
endinterface

`default_nettype wire

@@ rtl/rirb_out_if.sv @@
// Result channel of the ranked insert/remove buffer.
// Carries valid, ready and one result beat; widths from rirb_pkg.
`default_nettype none

interface rirb_out_if;
  logic                            valid;
  logic                            ready;
  logic [rirb_pkg::DATA_W-1:0]     read_data;
  logic [rirb_pkg::COUNT_W-1:0]    count;
  logic [rirb_pkg::STATUS_W-1:0]   status;

  modport source (output valid, output read_data, output count, output status,
                  input ready);
  modport sink (input valid, input read_data, input count, input status,
                output ready);
endinterface

`default_nettype wire

@@ rtl/ranked_insert_remove_buffer_top.sv @@
// Top level of the ranked insert/remove buffer: controller, row of storage
// cells and result register. Depends on rirb_pkg, rirb_in_if, rirb_out_if,
// rirb_ctrl and rirb_cell.
`default_nettype none

// The buffer takes one operation beat per clock cycle while the output is not
// stalled. Every cell of the row loads its new entry in the same cycle, so an
// insert or remove moves the whole list at once, and the result is registered
// when the beat is accepted. A new beat is taken whenever the output register
// is empty or is being emptied in the same cycle. Ranks reach the first sixteen
// entries; the count field shows the low five bits of the fill count.
module ranked_insert_remove_buffer_top #(
  parameter int DEPTH = rirb_pkg::DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rirb_in_if.sink     in_ch,
  rirb_out_if.source  out_ch
);

  localparam int FW    = $clog2(DEPTH + 1);
  localparam int CMP_W = (FW > rirb_pkg::RANK_W) ? FW : rirb_pkg::RANK_W;
  localparam int RD_N  = (DEPTH < 16) ? DEPTH : 16;
  localparam int RD_W  = (RD_N > 1) ? $clog2(RD_N) : 1;

  rirb_pkg::cmd_t                  cmd;
  logic [rirb_pkg::STATUS_W-1:0]   status;
  logic [rirb_pkg::COUNT_W-1:0]    count;
  logic [FW-1:0]                   fill;
  logic                            in_acc;
  logic [rirb_pkg::DATA_W-1:0]     cell_q [DEPTH];
  logic [rirb_pkg::DATA_W-1:0]     rd_word;

  logic                            out_valid_r;
  logic [rirb_pkg::DATA_W-1:0]     rd_r;
  logic [rirb_pkg::COUNT_W-1:0]    count_r;
  logic [rirb_pkg::STATUS_W-1:0]   status_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  rirb_ctrl #(
    .DEPTH (DEPTH),
    .FW    (FW),
    .CMP_W (CMP_W)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_acc),
    .mode   (in_ch.mode),
    .rank   (in_ch.rank),
    .value  (in_ch.value),
    .cmd    (cmd),
    .status (status),
    .count  (count),
    .fill   (fill)
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [rirb_pkg::DATA_W-1:0] left_d;
    logic [rirb_pkg::DATA_W-1:0] right_d;

    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_d = cell_q[g];
    end else begin : g_mid_r
      assign right_d = cell_q[g+1];
    end

    rirb_cell #(
      .IDX   (g),
      .CMP_W (CMP_W)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .left_data  (left_d),
      .right_data (right_d),
      .data_r     (cell_q[g])
    );
  end

  assign rd_word = cell_q[in_ch.rank[RD_W-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_r     <= cmd.rd ? rd_word : '0;
      count_r  <= count;
      status_r <= status;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = rd_r;
  assign out_ch.count     = count_r;
  assign out_ch.status    = status_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill <= FW'(DEPTH))
    else $error("fill count above depth");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> fill == $past(fill) + FW'(1))
    else $error("insert did not grow the list");

  a_rem_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rem |=> fill == $past(fill) - FW'(1))
    else $error("remove did not shrink the list");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && status == rirb_pkg::ST_FULL |-> fill == FW'(DEPTH))
    else $error("full status while list not full");

  a_err_no_op: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && status != rirb_pkg::ST_OK |-> !cmd.ins && !cmd.rem && !cmd.wr)
    else $error("rejected beat changed the list");
`endif

endmodule

`default_nettype wire

@@ rtl/rirb_cell.sv @@
// One storage cell of the shift row: holds one entry and loads it from its
// left or right neighbor or from the broadcast command. Depends on rirb_pkg.
`default_nettype none

module rirb_cell #(
  parameter int IDX   = 0,
  parameter int CMP_W = 5
) (
  input  wire logic                        clk,
  input  wire rirb_pkg::cmd_t              cmd,
  input  wire logic [rirb_pkg::DATA_W-1:0] left_data,
  input  wire logic [rirb_pkg::DATA_W-1:0] right_data,
  output logic      [rirb_pkg::DATA_W-1:0] data_r
);

  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

  logic [CMP_W-1:0]            rank_x;
  logic                        at_rank;
  logic                        above_rank;
  logic [rirb_pkg::DATA_W-1:0] data_nxt;

  assign rank_x     = CMP_W'(cmd.rank);
  assign at_rank    = (MY_IDX == rank_x);
  assign above_rank = (MY_IDX > rank_x);

  always_comb begin
    data_nxt = data_r;
    if (cmd.ins) begin
      if (above_rank) begin
        data_nxt = left_data;
      end else if (at_rank) begin
        data_nxt = cmd.value;
      end
    end else if (cmd.rem) begin
      if (above_rank || at_rank) begin
        data_nxt = right_data;
      end
    end else if (cmd.wr) begin
      if (at_rank) begin
        data_nxt = cmd.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/rirb_ctrl.sv @@
// Controller of the ranked insert/remove buffer: holds the fill count,
// checks rank and fullness, and drives the cell command. Depends on rirb_pkg.
`default_nettype none

module rirb_ctrl #(
  parameter int DEPTH = rirb_pkg::DEPTH_DEF,
  parameter int FW    = 5,
  parameter int CMP_W = 5
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          accept,
  input  wire logic [rirb_pkg::MODE_W-1:0]   mode,
  input  wire logic [rirb_pkg::RANK_W-1:0]   rank,
  input  wire logic [rirb_pkg::DATA_W-1:0]   value,
  output rirb_pkg::cmd_t                     cmd,
  output logic      [rirb_pkg::STATUS_W-1:0] status,
  output logic      [rirb_pkg::COUNT_W-1:0]  count,
  output logic      [FW-1:0]                 fill
);

  logic [FW-1:0]    fill_r;
  logic [FW-1:0]    fill_nxt;
  logic [CMP_W-1:0] rank_x;
  logic [CMP_W-1:0] fill_x;
  logic             is_full;
  logic             ok;

  assign rank_x  = CMP_W'(rank);
  assign fill_x  = CMP_W'(fill_r);
  assign is_full = (fill_r == FW'(DEPTH));

  always_comb begin
    status = rirb_pkg::ST_OK;
    case (mode)
      rirb_pkg::MODE_INSERT: begin
        if (rank_x > fill_x) begin
          status = rirb_pkg::ST_RANGE;
        end else if (is_full) begin
          status = rirb_pkg::ST_FULL;
        end
      end
      rirb_pkg::MODE_READ, rirb_pkg::MODE_REPLACE, rirb_pkg::MODE_REMOVE: begin
        if (!(rank_x < fill_x)) begin
          status = rirb_pkg::ST_RANGE;
        end
      end
      default: status = rirb_pkg::ST_RANGE;
    endcase
  end

  assign ok = accept && (status == rirb_pkg::ST_OK);

  always_comb begin
    cmd.ins   = ok && (mode == rirb_pkg::MODE_INSERT);
    cmd.rem   = ok && (mode == rirb_pkg::MODE_REMOVE);
    cmd.wr    = ok && (mode == rirb_pkg::MODE_REPLACE);
    cmd.rd    = ok && (mode == rirb_pkg::MODE_READ);
    cmd.rank  = rank;
    cmd.value = value;
  end

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.ins) begin
      fill_nxt = fill_r + FW'(1);
    end else if (cmd.rem) begin
      fill_nxt = fill_r - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign count = rirb_pkg::COUNT_W'(fill_nxt);
  assign fill  = fill_r;

endmodule

`default_nettype wire
